@@ design/sliding_window_prefetch_manager_macros.svh @@
`ifndef SLIDING_WINDOW_PREFETCH_MANAGER_MACROS_SVH
`define SLIDING_WINDOW_PREFETCH_MANAGER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SWPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SWPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/swpm_pkg.sv @@
`default_nettype none

package swpm_pkg;

  localparam int MAX_ITEMS  = 65536;
  localparam int MAX_WINDOW = 4096;

  localparam int IDX_W = 16;
  localparam int TOT_W = 17;
  localparam int CFG_W = 13;
  localparam int AR_W  = 19;

  typedef logic signed [AR_W-1:0] arith_t;

  localparam arith_t MAX_WIN_A = arith_t'(MAX_WINDOW);

  // event codes
  localparam logic [1:0] REQ_SET_POS   = 2'd0;
  localparam logic [1:0] REQ_REMOVED   = 2'd1;
  localparam logic [1:0] REQ_INSERTED  = 2'd2;
  localparam logic [1:0] REQ_SET_TOTAL = 2'd3;

  localparam logic KIND_RELEASE = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  localparam logic [1:0] DIR_NONE  = 2'd0;
  localparam logic [1:0] DIR_RESET = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  // register indexes
  localparam logic [1:0] CFG_WINDOW_SIZE = 2'd0;
  localparam logic [1:0] CFG_MOVE_THR    = 2'd1;
  localparam logic [1:0] CFG_OWNER       = 2'd2;

  typedef struct packed {
    logic [CFG_W-1:0] window_size;
    logic [CFG_W-1:0] move_thr;
    logic             owner;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] ws;
    logic [TOT_W-1:0] total;
    logic             rp;
  } state_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [IDX_W-1:0] item_index;
    logic [TOT_W-1:0] total_count;
  } item_t;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] last;
    logic [1:0]       dir;
    logic             own;
    logic             last_of_run;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } qload_t;

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] last;
  } range_t;

  // [start, start+count) clipped to [0, total-1]
  function automatic range_t clip_range(arith_t start, arith_t count, arith_t total);
    arith_t e;
    arith_t s;
    range_t r;
    e = start + count;
    if (e > total) e = total;
    e = e - arith_t'(1);
    s = start;
    if (s < 0) s = '0;
    r.ok    = (e >= s);
    r.first = s[IDX_W-1:0];
    r.last  = e[IDX_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/swpm_calc.sv @@
`default_nettype none

module swpm_calc (
  input  wire swpm_pkg::cfg_t   cfg,
  input  wire swpm_pkg::state_t st,
  input  wire swpm_pkg::item_t  item,
  output swpm_pkg::qload_t      qload,
  output swpm_pkg::state_t      st_nxt
);

  swpm_pkg::arith_t w, half, tot, tot_new, ws, idx, thr;
  swpm_pkg::arith_t t0, tmax, target, diff, mag, np1, np, ws_edge;
  logic             forced, t_lo, t_hi, big;
  logic [swpm_pkg::TOT_W-1:0] tot_sat;
  swpm_pkg::range_t ra, rb;
  logic             a_v, b_v, in_win;
  swpm_pkg::res_t   a, b;

  always_comb begin
    if (cfg.window_size == '0) w = swpm_pkg::arith_t'(1);
    else if ({6'b0, cfg.window_size} > swpm_pkg::MAX_WIN_A) w = swpm_pkg::MAX_WIN_A;
    else w = {6'b0, cfg.window_size};
    half = w >>> 1;
    thr  = {6'b0, cfg.move_thr};
    ws   = {3'b0, st.ws};
    tot  = {2'b0, st.total};
    idx  = {3'b0, item.item_index};

    if (item.total_count > swpm_pkg::TOT_W'(swpm_pkg::MAX_ITEMS))
      tot_sat = swpm_pkg::TOT_W'(swpm_pkg::MAX_ITEMS);
    else
      tot_sat = item.total_count;
    tot_new = {2'b0, tot_sat};

    // centre the window, clamped to the list
    t0     = idx - half;
    tmax   = tot - w;
    t_lo   = (t0 < 0);
    t_hi   = !t_lo && (t0 > tmax);
    target = t_lo ? '0 : (t_hi ? tmax : t0);
    forced = t_lo || t_hi;
    diff   = ws - target;
    mag    = (diff < 0) ? -diff : diff;
    big    = (mag >= w) || st.rp;
    np1    = (target + w > tot - swpm_pkg::arith_t'(1)) ? tmax : target;
    np     = (np1 < 0) ? '0 : np1;
    ws_edge = (target < 0) ? '0 : target;

    in_win = (idx >= ws) && (idx < ws + w);

    st_nxt = st;
    a_v = 1'b0;
    b_v = 1'b0;
    a   = '0;
    b   = '0;
    ra  = '0;
    rb  = '0;

    case (item.req_type)
      swpm_pkg::REQ_SET_POS: begin
        if (big) begin
          ra  = swpm_pkg::clip_range(ws, w, tot);
          rb  = swpm_pkg::clip_range(np, w, tot);
          a_v = ra.ok && !st.rp;
          a   = '{swpm_pkg::KIND_RELEASE, ra.first, ra.last, swpm_pkg::DIR_NONE, cfg.owner,
                  1'b0};
          b_v = rb.ok;
          b   = '{swpm_pkg::KIND_REQUEST, rb.first, rb.last, swpm_pkg::DIR_RESET, 1'b0, 1'b0};
          st_nxt.ws = np[swpm_pkg::IDX_W-1:0];
          st_nxt.rp = 1'b0;
        end else if (diff != 0 && (mag >= thr || forced)) begin
          if (diff < 0) begin
            ra = swpm_pkg::clip_range(ws, mag, tot);
            rb = swpm_pkg::clip_range(ws + w, mag, tot);
            b  = '{swpm_pkg::KIND_REQUEST, rb.first, rb.last, swpm_pkg::DIR_DOWN, 1'b0, 1'b0};
          end else begin
            ra = swpm_pkg::clip_range(ws + w - diff, mag, tot);
            rb = swpm_pkg::clip_range(ws - diff, mag, tot);
            b  = '{swpm_pkg::KIND_REQUEST, rb.first, rb.last, swpm_pkg::DIR_UP, 1'b0, 1'b0};
          end
          a_v = ra.ok;
          a   = '{swpm_pkg::KIND_RELEASE, ra.first, ra.last, swpm_pkg::DIR_NONE, cfg.owner,
                  1'b0};
          b_v = rb.ok;
          st_nxt.ws = ws_edge[swpm_pkg::IDX_W-1:0];
        end
      end
      swpm_pkg::REQ_SET_TOTAL: begin
        st_nxt.total = tot_sat;
      end
      swpm_pkg::REQ_REMOVED: begin
        st_nxt.total = tot_sat;
        if (in_win) begin
          a_v = 1'b1;
          a   = '{swpm_pkg::KIND_RELEASE, item.item_index, item.item_index, swpm_pkg::DIR_NONE,
                  1'b0, 1'b0};
          if (tot_new >= w) begin
            if (ws + w <= tot_new) begin
              b_v = 1'b1;
              b   = '{swpm_pkg::KIND_REQUEST, st.ws + swpm_pkg::IDX_W'(w - 1),
                      st.ws + swpm_pkg::IDX_W'(w - 1), swpm_pkg::DIR_NONE, 1'b0, 1'b0};
            end else if (st.ws != '0) begin
              // shift the window back by one to stay inside the shorter list
              b_v = 1'b1;
              b   = '{swpm_pkg::KIND_REQUEST, st.ws - 1'b1, st.ws - 1'b1,
                      swpm_pkg::DIR_NONE, 1'b0, 1'b0};
              st_nxt.ws = st.ws - 1'b1;
            end
          end
        end
      end
      swpm_pkg::REQ_INSERTED: begin
        st_nxt.total = tot_sat;
        if (in_win) begin
          if (tot_new > w && ws + w < tot_new) begin
            a_v = 1'b1;
            a   = '{swpm_pkg::KIND_RELEASE, st.ws + swpm_pkg::IDX_W'(w),
                    st.ws + swpm_pkg::IDX_W'(w), swpm_pkg::DIR_NONE, cfg.owner, 1'b0};
          end
          b_v = 1'b1;
          b   = '{swpm_pkg::KIND_REQUEST, item.item_index, item.item_index, swpm_pkg::DIR_NONE,
                  1'b0, 1'b0};
        end
      end
      default: begin
        st_nxt = st;
      end
    endcase

    // pack the two candidates, mark the final one
    qload = '0;
    if (a_v) begin
      qload.r0 = a;
      qload.r1 = b;
      qload.r1.last_of_run = 1'b1;
      qload.r0.last_of_run = !b_v;
      qload.n  = b_v ? 2'd2 : 2'd1;
    end else begin
      qload.r0 = b;
      qload.r1 = b;
      qload.r0.last_of_run = 1'b1;
      qload.n  = b_v ? 2'd1 : 2'd0;
    end
  end

endmodule

`default_nettype wire

@@ design/swpm_outq.sv @@
`default_nettype none

module swpm_outq (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   load,
  input  wire swpm_pkg::qload_t ld,
  output logic                  can_load,
  output logic                  out_valid,
  input  wire                   out_ready,
  output swpm_pkg::res_t        head
);

  logic [1:0]     cnt_r, cnt_nxt;
  swpm_pkg::res_t slot0_r, slot1_r;
  logic           pop;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign can_load  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign head      = slot0_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (load) cnt_nxt = ld.n;
    else if (pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot0_r <= ld.r0;
      slot1_r <= ld.r1;
    end else if (pop) begin
      slot0_r <= slot1_r;
    end
  end

endmodule

`default_nettype wire

@@ design/sliding_window_prefetch_manager.sv @@
// A result passes two registers: the input register holds the accepted transaction,
// then the range logic loads the 2-entry result queue from it.
// Events with at most one result are taken one per cycle while out_ready is high; an
// event with a release and a request holds back the next until its release leaves the single result port.
// Reset (synchronous, rst_n low): window at 0, item total 0, reset pending set,
// window_size 32, move_threshold 8, owner reporting off, input and result empty.
`default_nettype none

`include "sliding_window_prefetch_manager_macros.svh"

module sliding_window_prefetch_manager (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [1:0]                   in_req_type,
  input  wire  [swpm_pkg::IDX_W-1:0]   in_item_index,
  input  wire  [swpm_pkg::TOT_W-1:0]   in_total_count,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         out_kind,
  output logic [swpm_pkg::IDX_W-1:0]   out_first_index,
  output logic [swpm_pkg::IDX_W-1:0]   out_last_index,
  output logic [1:0]                   out_direction,
  output logic                         out_to_owner,
  output logic                         out_last_of_run,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [1:0]                   cfg_index,
  input  wire  [swpm_pkg::CFG_W-1:0]   cfg_data
);

  swpm_pkg::cfg_t   cfg_r;
  swpm_pkg::state_t st_r, st_nxt;
  swpm_pkg::item_t  item_r;
  logic             in_vld_r;
  logic             fire, can_load;
  swpm_pkg::qload_t qload;
  swpm_pkg::res_t   head;

  assign cfg_ready = 1'b1;
  assign fire      = in_vld_r && can_load;
  assign in_ready  = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_size <= swpm_pkg::CFG_W'(32);
      cfg_r.move_thr    <= swpm_pkg::CFG_W'(8);
      cfg_r.owner       <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        swpm_pkg::CFG_WINDOW_SIZE: cfg_r.window_size <= cfg_data;
        swpm_pkg::CFG_MOVE_THR:    cfg_r.move_thr    <= cfg_data;
        swpm_pkg::CFG_OWNER:       cfg_r.owner       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      st_r     <= '{ws: '0, total: '0, rp: 1'b1};
    end else begin
      in_vld_r <= in_valid || (in_vld_r && !fire);
      if (fire) st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= '{req_type: in_req_type, item_index: in_item_index,
                  total_count: in_total_count};
    end
  end

  swpm_calc u_calc (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (item_r),
    .qload  (qload),
    .st_nxt (st_nxt)
  );

  swpm_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .ld        (qload),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_kind        = head.kind;
  assign out_first_index = head.first;
  assign out_last_index  = head.last;
  assign out_direction   = head.dir;
  assign out_to_owner    = head.own;
  assign out_last_of_run = head.last_of_run;

  // a run's non-final result must be followed by the rest of the run
  `SWPM_ASSERT_NEXT(a_run_continues, out_valid && out_ready && !out_last_of_run, out_valid,
                    "result run cut short")
  // only reset raises the pending-reset flag
  `SWPM_ASSERT_NEXT(a_rp_sticky_low, !st_r.rp, !st_r.rp, "reset pending set outside reset")
  // an event with no results must not produce output on an empty queue
  `SWPM_ASSERT_NEXT(a_no_phantom, fire && qload.n == 2'd0 && !out_valid, !out_valid,
                    "result invented")
  // a release never carries a direction
  `SWPM_ASSERT_NOW(a_dir_release, out_valid && out_kind == swpm_pkg::KIND_RELEASE,
                   out_direction == swpm_pkg::DIR_NONE, "release carries a direction")

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import swpm_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 60;

  class swpm_scoreboard;
    logic [CFG_W-1:0] win_reg;
    logic [CFG_W-1:0] thr_reg;
    logic             own_reg;
    longint           wstart;
    longint           total;
    bit               rst_pend;
    res_t             expq[$];
    int               errors;
    int               n_inputs;
    int               n_release;
    int               n_request;
    int               n_settings;

    function new();
      win_reg = 13'd32;
      thr_reg = 13'd8;
      own_reg = 1'b0;
      wstart = 0;
      total = 0;
      rst_pend = 1'b1;
    endfunction

    function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] d);
      n_settings++;
      case (idx)
        CFG_WINDOW_SIZE: win_reg = d;
        CFG_MOVE_THR:    thr_reg = d;
        CFG_OWNER:       own_reg = d[0];
        default: ;
      endcase
    endfunction

    function longint eff_win();
      longint w;
      w = win_reg;
      if (w < 1) w = 1;
      if (w > MAX_WINDOW) w = MAX_WINDOW;
      return w;
    endfunction

    function void push(logic kind, longint f, longint l, logic [1:0] dir, logic own);
      res_t r;
      r.kind = kind;
      r.first = f[15:0];
      r.last = l[15:0];
      r.dir = dir;
      r.own = own;
      r.last_of_run = 1'b0;
      expq.push_back(r);
    endfunction

    // [start, start+count) clipped to the list; dropped when empty
    function void push_clipped(logic kind, longint start, longint count, logic [1:0] dir,
                               logic own);
      longint e;
      e = start + count;
      if (e > total) e = total;
      e--;
      if (start < 0) start = 0;
      if (e >= start) push(kind, start, e, dir, own);
    endfunction

    function void note_input(item_t it);
      longint w, thr, idx, tot, target, diff, mag, np;
      bit forced;
      int n_prev;
      res_t r;
      w = eff_win();
      thr = thr_reg;
      idx = it.item_index;
      tot = it.total_count;
      if (tot > MAX_ITEMS) tot = MAX_ITEMS;
      n_prev = expq.size();
      forced = 1'b0;
      n_inputs++;
      case (it.req_type)
        REQ_SET_POS: begin
          target = idx - w / 2;
          if (target < 0) begin
            target = 0;
            forced = 1'b1;
          end else if (target > total - w) begin
            target = total - w;
            forced = 1'b1;
          end
          diff = wstart - target;
          mag = (diff < 0) ? -diff : diff;
          if (mag >= w || rst_pend) begin
            // full reload: drop the old window, fetch a fresh one
            np = target;
            if (!rst_pend) push_clipped(KIND_RELEASE, wstart, w, DIR_NONE, own_reg);
            if (np + w > total - 1) np = total - w;
            if (np < 0) np = 0;
            wstart = np;
            push_clipped(KIND_REQUEST, np, w, DIR_RESET, 1'b0);
            rst_pend = 1'b0;
          end else if (diff != 0 && (mag >= thr || forced)) begin
            if (diff < 0) begin
              push_clipped(KIND_RELEASE, wstart, mag, DIR_NONE, own_reg);
              push_clipped(KIND_REQUEST, wstart + w, mag, DIR_DOWN, 1'b0);
            end else begin
              push_clipped(KIND_RELEASE, wstart + w - diff, mag, DIR_NONE, own_reg);
              push_clipped(KIND_REQUEST, wstart - diff, mag, DIR_UP, 1'b0);
            end
            wstart -= diff;
            if (wstart < 0) wstart = 0;
          end
        end
        REQ_SET_TOTAL: total = tot;
        default: begin
          total = tot;
          if (idx >= wstart && idx < wstart + w) begin
            if (it.req_type == REQ_REMOVED) begin
              push(KIND_RELEASE, idx, idx, DIR_NONE, 1'b0);
              if (total >= w) begin
                if (wstart + w <= total) begin
                  push(KIND_REQUEST, wstart + w - 1, wstart + w - 1, DIR_NONE, 1'b0);
                end else if (wstart > 0) begin
                  wstart--;
                  push(KIND_REQUEST, wstart, wstart, DIR_NONE, 1'b0);
                end
              end
            end else begin
              if (total > w && wstart + w < total)
                push(KIND_RELEASE, wstart + w, wstart + w, DIR_NONE, own_reg);
              push(KIND_REQUEST, idx, idx, DIR_NONE, 1'b0);
            end
          end
        end
      endcase
      if (expq.size() > n_prev) begin
        r = expq.pop_back();
        r.last_of_run = 1'b1;
        expq.push_back(r);
      end
    endfunction

    function void cmp(string name, logic [15:0] e, logic [15:0] a);
      if (e !== a) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, e, a);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (got.kind == KIND_RELEASE) n_release++;
      else n_request++;
      if (expq.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: unexpected range: expected none, got kind %0d [%0d..%0d]",
                   $time, got.kind, got.first, got.last);
        return;
      end
      want = expq.pop_front();
      cmp("kind", 16'(want.kind), 16'(got.kind));
      cmp("first_index", want.first, got.first);
      cmp("last_index", want.last, got.last);
      cmp("direction", 16'(want.dir), 16'(got.dir));
      cmp("to_owner", 16'(want.own), 16'(got.own));
      cmp("last_of_run", 16'(want.last_of_run), 16'(got.last_of_run));
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_req_type;
  logic [IDX_W-1:0]   in_item_index;
  logic [TOT_W-1:0]   in_total_count;
  logic               out_valid;
  logic               out_ready;
  logic               out_kind;
  logic [IDX_W-1:0]   out_first_index;
  logic [IDX_W-1:0]   out_last_index;
  logic [1:0]         out_direction;
  logic               out_to_owner;
  logic               out_last_of_run;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [CFG_W-1:0]   cfg_data;

  swpm_scoreboard sb;
  bit             quiet;
  int             cycle_count;

  sliding_window_prefetch_manager dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_item_index   (in_item_index),
    .in_total_count  (in_total_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_first_index (out_first_index),
    .out_last_index  (out_last_index),
    .out_direction   (out_direction),
    .out_to_owner    (out_to_owner),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // result side: random back-pressure, each transaction checked on acceptance
  initial begin
    int stall;
    res_t got;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.kind = out_kind;
      got.first = out_first_index;
      got.last = out_last_index;
      got.dir = out_direction;
      got.own = out_to_owner;
      got.last_of_run = out_last_of_run;
      sb.check_result(got);
    end
  end

  function automatic item_t mk(logic [1:0] t, int unsigned i, int unsigned c);
    item_t x;
    x.req_type = t;
    x.item_index = i[15:0];
    x.total_count = c[16:0];
    return x;
  endfunction

  task automatic send_item(item_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= it.req_type;
    in_item_index <= it.item_index;
    in_total_count <= it.total_count;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [CFG_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, d);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // hold the sender until every outstanding range has been seen
  task automatic drain(int tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expq.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  function automatic longint clamp_idx(longint v);
    if (v < 0) return 0;
    if (v > 65535) return 65535;
    return v;
  endfunction

  // mostly events aimed at the live window so that moves, edges and
  // in-window changes are hit often; the rest is scattered
  function automatic item_t pick_item();
    item_t it;
    longint w, thr, ws, tot, off, sgn, c;
    int r;
    w = sb.eff_win();
    thr = sb.thr_reg;
    ws = sb.wstart;
    tot = sb.total;
    it.req_type = REQ_SET_POS;
    it.item_index = 16'($urandom);
    it.total_count = 17'($urandom);
    r = $urandom_range(0, 99);
    if (r < 8) begin
      it.req_type = REQ_SET_TOTAL;
      case ($urandom_range(0, 3))
        0: it.total_count = 17'($urandom_range(0, 32'(2 * w)));
        1: it.total_count = 17'($urandom_range(32'(w), 32'(4 * w + 64)));
        2: it.total_count = 17'(MAX_ITEMS);
        default: ;
      endcase
    end else if (r < 60) begin
      sgn = $urandom_range(0, 1) ? 1 : -1;
      case ($urandom_range(0, 7))
        0: off = $urandom_range(0, 32'(thr) + 1);
        1: off = thr - 1 + longint'($urandom_range(0, 2));
        2, 3: off = $urandom_range(0, 32'(2 * w));
        4: off = w - 1 + longint'($urandom_range(0, 2));
        5: off = -1;
        default: off = $urandom_range(0, 3);
      endcase
      if (off < 0) begin
        if ($urandom_range(0, 2) != 0)
          it.item_index = $urandom_range(0, 1) ? 16'd0 : 16'(clamp_idx(tot - 1));
      end else begin
        c = ws + w / 2 + sgn * off;
        it.item_index = 16'(clamp_idx(c));
      end
    end else begin
      it.req_type = (r < 80) ? REQ_REMOVED : REQ_INSERTED;
      case ($urandom_range(0, 9))
        0: it.item_index = 16'(clamp_idx(ws - 1));
        1: it.item_index = 16'(clamp_idx(ws + w));
        2: it.item_index = 16'(clamp_idx(ws + w - 1));
        3: ;
        default: it.item_index = 16'(clamp_idx(ws + longint'($urandom_range(0, 32'(w - 1)))));
      endcase
      case ($urandom_range(0, 9))
        0: ;
        1, 2, 3: it.total_count = 17'(tot);
        default: begin
          if (it.req_type == REQ_REMOVED) it.total_count = (tot > 0) ? 17'(tot - 1) : 17'd0;
          else it.total_count = (tot < MAX_ITEMS) ? 17'(tot + 1) : 17'(tot);
        end
      endcase
    end
    return it;
  endfunction

  task automatic run_phase(int unsigned w, int unsigned thr, bit own, int unsigned tot);
    logic [CFG_W-1:0] d;
    drain(4);
    cfg_write(CFG_WINDOW_SIZE, w[CFG_W-1:0]);
    cfg_write(CFG_MOVE_THR, thr[CFG_W-1:0]);
    d = CFG_W'($urandom);
    d[0] = own;
    cfg_write(CFG_OWNER, d);
    send_item(mk(REQ_SET_TOTAL, $urandom, tot));
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      if (k % 24 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_item(pick_item());
    end
  endtask

  initial begin
    item_t directed[$];
    int unsigned rw;
    sb = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_req_type <= REQ_SET_POS;
    in_item_index <= '0;
    in_total_count <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_WINDOW_SIZE;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values: window 32, threshold 8, no owner reporting
    directed.push_back(mk(REQ_REMOVED, 5, 40));        // change before first position
    directed.push_back(mk(REQ_SET_TOTAL, 0, 100));
    directed.push_back(mk(REQ_SET_POS, 50, 17'h1FFFF)); // pending reset: full fetch
    directed.push_back(mk(REQ_SET_POS, 53, 0));        // below threshold
    directed.push_back(mk(REQ_SET_POS, 58, 0));        // at threshold, scroll down
    directed.push_back(mk(REQ_SET_POS, 50, 0));        // scroll up
    directed.push_back(mk(REQ_SET_POS, 0, 0));         // clamped at start, full jump
    directed.push_back(mk(REQ_SET_POS, 18, 0));
    directed.push_back(mk(REQ_SET_POS, 99, 0));        // clamped at end
    directed.push_back(mk(REQ_SET_POS, 80, 0));
    directed.push_back(mk(REQ_SET_POS, 65535, 0));
    directed.push_back(mk(REQ_REMOVED, 70, 99));
    directed.push_back(mk(REQ_INSERTED, 99, 100));
    directed.push_back(mk(REQ_REMOVED, 10, 100));      // outside the window
    directed.push_back(mk(REQ_INSERTED, 68, 100));
    directed.push_back(mk(REQ_SET_TOTAL, 65535, 17'h1FFFF)); // saturates
    directed.push_back(mk(REQ_SET_POS, 65535, 0));
    directed.push_back(mk(REQ_REMOVED, 65535, 65536));
    directed.push_back(mk(REQ_INSERTED, 65504, 65536));
    directed.push_back(mk(REQ_SET_TOTAL, 0, 10));      // list shorter than window
    directed.push_back(mk(REQ_SET_POS, 5, 0));
    directed.push_back(mk(REQ_REMOVED, 3, 9));
    directed.push_back(mk(REQ_INSERTED, 0, 10));
    directed.push_back(mk(REQ_SET_TOTAL, 0, 0));
    directed.push_back(mk(REQ_SET_POS, 0, 0));         // empty list, nothing emitted
    foreach (directed[i]) send_item(directed[i]);

    run_phase(32, 8, 1'b1, $urandom_range(0, 400));
    run_phase(0, 0, 1'b0, $urandom_range(0, 64));
    run_phase(1, 1, 1'b1, $urandom_range(1, 200));
    run_phase(4096, 4096, 1'b1, $urandom_range(4096, 65536));
    run_phase(8191, 8191, 1'b0, MAX_ITEMS);
    drain(4);
    cfg_write(CFG_UNUSED, CFG_W'($urandom));
    rw = $urandom_range(2, 300);
    run_phase(rw, $urandom_range(1, rw), 1'($urandom), $urandom_range(0, 4 * rw));
    rw = $urandom_range(1, 4096);
    run_phase(rw, $urandom_range(0, 8191), 1'($urandom), $urandom_range(0, 131071));

    drain(10);
    $display("covered %0d events, %0d ranges (%0d released, %0d requested)",
             sb.n_inputs, sb.n_release + sb.n_request, sb.n_release, sb.n_request);
    $display("over %0d register writes including window and threshold extremes",
             sb.n_settings);
    if (sb.errors == 0 && sb.expq.size() == 0) begin
      $display("tb passed");
    end else begin
      if (sb.expq.size() != 0)
        $display("%0t: %0d expected ranges never arrived", $time, sb.expq.size());
      $display("tb failed");
    end
    $finish;
  end

endmodule
